>>> hw/rtl/lda_pkg.sv
`default_nettype none

package lda_pkg;

    // One surface point
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    // One attenuation result
    typedef struct packed {
        logic [31:0] factor;
        logic        saturated;
    } result_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND   = 3'd0,
        REG_MODE   = 3'd1,
        REG_POS_X  = 3'd2,
        REG_POS_Y  = 3'd3,
        REG_POS_Z  = 3'd4,
        REG_RADIUS = 3'd5
    } cfg_reg_t;

    // Light kinds and falloff modes
    localparam logic [1:0] KIND_POINT   = 2'd0;
    localparam logic [1:0] KIND_SPOT    = 2'd1;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_INVSQ   = 2'd2;

    // How an item's factor is formed at the end of the pipe
    typedef enum logic [2:0] {
        RES_ONE  = 3'd0,
        RES_ZERO = 3'd1,
        RES_SAT  = 3'd2,
        RES_LIN  = 3'd3,
        RES_DIV  = 3'd4
    } res_code_t;

    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [31:0] FACTOR_MAX = 32'hFFFF_FFFF;

    // Pipeline depth
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 32;
    localparam int LATENCY    = 4 + SQRT_STEPS + DIV_STEPS + 2;

    // Front stages
    typedef struct packed {
        logic        valid;
        res_code_t   code;
        logic [32:0] mag_x;
        logic [32:0] mag_y;
        logic [32:0] mag_z;
    } diff_stage_t;

    typedef struct packed {
        logic        valid;
        res_code_t   code;
        logic [65:0] sq_x;
        logic [65:0] sq_y;
        logic [65:0] sq_z;
    } square_stage_t;

    typedef struct packed {
        logic        valid;
        res_code_t   code;
        logic [65:0] dist2;
    } sum_stage_t;

    // Square root stage: one result bit per stage
    typedef struct packed {
        logic        valid;
        res_code_t   code;
        logic [65:0] dist2;
        logic [30:0] root;
        logic [33:0] rem;
    } sqrt_stage_t;

    // Divider stage: one quotient bit per stage
    typedef struct packed {
        logic        valid;
        res_code_t   code;
        logic [65:0] den;
        logic [31:0] num_lo;
        logic [65:0] rem;
        logic [31:0] quo;
    } div_stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/light_distance_attenuation.sv
`default_nettype none

// Channel   Ports                               Handshake
// --------  ----------------------------------  -------------------------------
// input     start, busy, point                  taken when start && !busy
// result    done, result                        one-cycle done strobe per item
// config    cfg_valid, cfg_ready, cfg_index,    written when cfg_valid &&
//           cfg_data                            cfg_ready
//
// A new point is taken every cycle; busy stays low. Each result passes
// through 31 square-root stages and 32 divider stages, each retiring one
// bit. Reset clears all valid bits and loads the register defaults. The
// receiver cannot stall, so the pipe never holds.

module light_distance_attenuation (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output      logic                                 busy,
    input  wire lda_pkg::point_t                      point,
    output      logic                                 done,
    output      lda_pkg::result_t                     result,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [lda_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [31:0]                          cfg_data
);

    // Configuration registers
    logic [1:0]         kind_reg;
    logic [1:0]         mode_reg;
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic signed [31:0] pos_z_reg;
    logic [30:0]        radius_reg;
    logic [61:0]        r2_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= 2'd0;
            mode_reg   <= 2'd1;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            radius_reg <= 31'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lda_pkg::REG_KIND:   kind_reg   <= cfg_data[1:0];
                lda_pkg::REG_MODE:   mode_reg   <= cfg_data[1:0];
                lda_pkg::REG_POS_X:  pos_x_reg  <= cfg_data;
                lda_pkg::REG_POS_Y:  pos_y_reg  <= cfg_data;
                lda_pkg::REG_POS_Z:  pos_z_reg  <= cfg_data;
                lda_pkg::REG_RADIUS: radius_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // r*r follows the radius in the next cycle; first use is three stages in
    always_ff @(posedge clk)
    begin
        r2_reg <= radius_reg * radius_reg;
    end

    // Stage 0: differences and magnitudes
    lda_pkg::diff_stage_t diff_reg, diff_next;
    logic signed [32:0]   dx, dy, dz;

    always_comb
    begin
        dx = {point.point_x[31], point.point_x} - {pos_x_reg[31], pos_x_reg};
        dy = {point.point_y[31], point.point_y} - {pos_y_reg[31], pos_y_reg};
        dz = {point.point_z[31], point.point_z} - {pos_z_reg[31], pos_z_reg};
        diff_next.valid = start && !busy;
        diff_next.mag_x = dx[32] ? 33'(-dx) : 33'(dx);
        diff_next.mag_y = dy[32] ? 33'(-dy) : 33'(dy);
        diff_next.mag_z = dz[32] ? 33'(-dz) : 33'(dz);
        if ((kind_reg == lda_pkg::KIND_POINT || kind_reg == lda_pkg::KIND_SPOT)
            && mode_reg == lda_pkg::MODE_LINEAR)
            diff_next.code = lda_pkg::RES_LIN;
        else if ((kind_reg == lda_pkg::KIND_POINT || kind_reg == lda_pkg::KIND_SPOT)
                 && mode_reg == lda_pkg::MODE_INVSQ)
            diff_next.code = lda_pkg::RES_DIV;
        else
            diff_next.code = lda_pkg::RES_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            diff_reg <= '0;
        else
            diff_reg <= diff_next;
    end

    // Stage 1: squares
    lda_pkg::square_stage_t square_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            square_reg <= '0;
        else
        begin
            square_reg.valid <= diff_reg.valid;
            square_reg.code  <= diff_reg.code;
            square_reg.sq_x  <= diff_reg.mag_x * diff_reg.mag_x;
            square_reg.sq_y  <= diff_reg.mag_y * diff_reg.mag_y;
            square_reg.sq_z  <= diff_reg.mag_z * diff_reg.mag_z;
        end
    end

    // Stage 2: squared distance, below 2^66
    lda_pkg::sum_stage_t sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
        begin
            sum_reg.valid <= square_reg.valid;
            sum_reg.code  <= square_reg.code;
            sum_reg.dist2 <= square_reg.sq_x + square_reg.sq_y + square_reg.sq_z;
        end
    end

    // Stage 3: out-of-radius and clamp decisions
    lda_pkg::sqrt_stage_t sq_reg [lda_pkg::SQRT_STEPS+1];
    lda_pkg::sqrt_stage_t sq_first_next;

    always_comb
    begin
        sq_first_next.valid = sum_reg.valid;
        sq_first_next.dist2 = sum_reg.dist2;
        sq_first_next.root  = '0;
        sq_first_next.rem   = '0;
        case (sum_reg.code)
            lda_pkg::RES_LIN:
                sq_first_next.code = (sum_reg.dist2 >= {4'd0, r2_reg})
                                     ? lda_pkg::RES_ZERO : lda_pkg::RES_LIN;
            lda_pkg::RES_DIV:
                // clamp when D is zero or r2 >= D * 2^16
                sq_first_next.code = (sum_reg.dist2 == '0 ||
                                      sum_reg.dist2 <= {20'd0, r2_reg[61:16]})
                                     ? lda_pkg::RES_SAT : lda_pkg::RES_DIV;
            default:
                sq_first_next.code = sum_reg.code;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_reg[0] <= '0;
        else
            sq_reg[0] <= sq_first_next;
    end

    // Square root of D (below 2^62 on the linear path), two input bits per stage
    for (genvar j = 0; j < lda_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        localparam int K = lda_pkg::SQRT_STEPS - 1 - j;
        lda_pkg::sqrt_stage_t step_next;
        logic [33:0]          rem_sh;
        logic [33:0]          trial;

        always_comb
        begin
            rem_sh    = {sq_reg[j].rem[31:0], sq_reg[j].dist2[2*K+1 -: 2]};
            trial     = {1'b0, sq_reg[j].root, 2'b01};
            step_next = sq_reg[j];
            if (rem_sh >= trial)
            begin
                step_next.rem  = rem_sh - trial;
                step_next.root = {sq_reg[j].root[29:0], 1'b1};
            end
            else
            begin
                step_next.rem  = rem_sh;
                step_next.root = {sq_reg[j].root[29:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_reg[j+1] <= '0;
            else
                sq_reg[j+1] <= step_next;
        end
    end

    // Divider setup: linear divides (r - s) * 2^16 by r, inverse square r2 * 2^16 by D
    lda_pkg::div_stage_t   dv_reg [lda_pkg::DIV_STEPS+1];
    lda_pkg::div_stage_t   dv_first_next;
    lda_pkg::sqrt_stage_t  sq_last;
    logic [77:0]           num;
    logic [30:0]           lin_diff;

    always_comb
    begin
        sq_last             = sq_reg[lda_pkg::SQRT_STEPS];
        lin_diff            = radius_reg - sq_last.root;
        dv_first_next.valid = sq_last.valid;
        dv_first_next.quo   = '0;
        if (sq_last.code == lda_pkg::RES_LIN)
        begin
            num                = {31'd0, lin_diff, 16'd0};
            dv_first_next.den  = {35'd0, radius_reg};
            dv_first_next.code = lda_pkg::RES_DIV;
        end
        else
        begin
            num                = {r2_reg, 16'd0};
            dv_first_next.den  = sq_last.dist2;
            dv_first_next.code = sq_last.code;
        end
        dv_first_next.rem    = {20'd0, num[77:32]};
        dv_first_next.num_lo = num[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= '0;
        else
            dv_reg[0] <= dv_first_next;
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < lda_pkg::DIV_STEPS; j++)
    begin : g_div
        lda_pkg::div_stage_t step_next;
        logic [66:0]         rem_sh;
        logic [66:0]         rem_sub;

        always_comb
        begin
            rem_sh    = {dv_reg[j].rem, dv_reg[j].num_lo[31]};
            rem_sub   = rem_sh - {1'b0, dv_reg[j].den};
            step_next = dv_reg[j];
            step_next.num_lo = {dv_reg[j].num_lo[30:0], 1'b0};
            if (rem_sh >= {1'b0, dv_reg[j].den})
            begin
                step_next.rem = rem_sub[65:0];
                step_next.quo = {dv_reg[j].quo[30:0], 1'b1};
            end
            else
            begin
                step_next.rem = rem_sh[65:0];
                step_next.quo = {dv_reg[j].quo[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j+1] <= '0;
            else
                dv_reg[j+1] <= step_next;
        end
    end

    // Output register
    lda_pkg::div_stage_t dv_last;
    lda_pkg::result_t    result_next;
    lda_pkg::result_t    result_reg;
    logic                done_reg;

    always_comb
    begin
        dv_last               = dv_reg[lda_pkg::DIV_STEPS];
        result_next.saturated = 1'b0;
        case (dv_last.code)
            lda_pkg::RES_ZERO: result_next.factor = '0;
            lda_pkg::RES_DIV:  result_next.factor = dv_last.quo;
            lda_pkg::RES_SAT:
            begin
                result_next.factor    = lda_pkg::FACTOR_MAX;
                result_next.saturated = 1'b1;
            end
            default:           result_next.factor = lda_pkg::ONE_Q16;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_last.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // Every accepted point comes out after the pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(lda_pkg::LATENCY) done)
        else $error("result missing after pipeline latency");

    // No result without a point accepted one pipeline latency earlier
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, lda_pkg::LATENCY))
        else $error("result without a matching point");

    // A clamped result carries the maximum factor
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.saturated |-> result.factor == lda_pkg::FACTOR_MAX)
        else $error("saturated flag without maximum factor");
`endif

endmodule

`default_nettype wire
